// File: sv/lasd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasd_pkg
// Shared constants, types and tables for the lidar arc segment detector.
// ----------------------------------------------------------------------------
package lasd_pkg;

    localparam int MAX_BEAMS    = 4096;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int BEAM_W       = $clog2(MAX_BEAMS);
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic [29:0] KINV_Q30 = 30'd652032874;
    localparam logic [23:0] LEN_MAX  = 24'hFFFFFF;
    localparam logic [12:0] CNT_MAX  = 13'h1FFF;

    // register indexes
    localparam logic [2:0] REG_RANGE_MAX   = 3'd0;
    localparam logic [2:0] REG_RANGE_MIN   = 3'd1;
    localparam logic [2:0] REG_ANGLE_START = 3'd2;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd3;
    localparam logic [2:0] REG_JOIN_SQ     = 3'd4;
    localparam logic [2:0] REG_TARGET      = 3'd5;
    localparam logic [2:0] REG_TOL         = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_SCALE,
        ST_CORDIC,
        ST_ROUND,
        ST_DIFF,
        ST_SQUARE,
        ST_SQRT,
        ST_UPDATE,
        ST_FINISH,
        ST_OUT
    } state_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/lidar_arc_segment_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_arc_segment_detector
// Converts range samples to x/y by CORDIC, joins near points into segments
// and reports the first segment whose length falls in the target band.
// ----------------------------------------------------------------------------
//  channel  signals                                     dir
//  in       in_valid, in_stall, range_mm, last_in_scan  sink
//  out      out_valid, out_stall, found, seg_*          source
//  cfg      cfg_we, cfg_index, cfg_data                 sink
//
// A valid sample with a previous point runs ST_ANGLE, ST_SCALE, the CORDIC
// steps, ST_ROUND, ST_DIFF, ST_SQUARE, the square root walk, ST_UPDATE and
// ST_FINISH before the next intake. The first valid point of a scan skips
// ST_SQUARE and ST_SQRT; a skipped sample goes from ST_ANGLE to ST_FINISH.
// The input stalls while an item is in work. A last-of-scan item passes
// through ST_OUT and holds there while the previous result is still waiting.
// Reset clears all scan state and loads the register defaults.
module lidar_arc_segment_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] range_mm,
    input  logic        last_in_scan,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [12:0] seg_points,
    output logic signed [28:0] seg_sum_x,
    output logic signed [28:0] seg_sum_y,
    output logic [23:0] seg_length_mm,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lasd_pkg::*;

    logic [15:0] rmax_reg, rmin_reg, astart_reg, astep_reg, target_reg, tol_reg;
    logic [31:0] join_reg;

    state_t state_reg, state_next;
    logic [BEAM_W-1:0] beam_reg, beam_next;
    logic signed [16:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic have_prev_reg, have_prev_next, in_seg_reg, in_seg_next;
    logic found_reg, found_next;
    logic [23:0] len_reg, len_next;
    logic signed [28:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [12:0] cnt_reg, cnt_next;

    // working registers
    logic [15:0] r_reg, r_next;
    logic last_reg, last_next;
    logic [1:0] q_reg, q_next;
    logic signed [32:0] z_reg, z_next;
    logic signed [35:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [5:0] step_reg, step_next;
    logic signed [16:0] x_reg, x_next, y_reg, y_next;
    logic signed [17:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [34:0] d2_reg, d2_next;
    logic [34:0] rem_reg, rem_next, root_reg, root_next, bit_reg, bit_next;
    logic sq_phase_reg, sq_phase_next;
    logic [23:0] gap_reg, gap_next;

    logic out_valid_reg, out_valid_next, o_found_reg, o_found_next;
    logic [12:0] o_cnt_reg, o_cnt_next;
    logic signed [28:0] o_sx_reg, o_sx_next, o_sy_reg, o_sy_next;
    logic [23:0] o_len_reg, o_len_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmax_reg   <= 16'd2600;
            rmin_reg   <= 16'd120;
            astart_reg <= 16'd32768;
            astep_reg  <= 16'd182;
            join_reg   <= 32'd200000;
            target_reg <= 16'd471;
            tol_reg    <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_MAX:   rmax_reg   <= cfg_data[15:0];
                REG_RANGE_MIN:   rmin_reg   <= cfg_data[15:0];
                REG_ANGLE_START: astart_reg <= cfg_data[15:0];
                REG_ANGLE_STEP:  astep_reg  <= cfg_data[15:0];
                REG_JOIN_SQ:     join_reg   <= cfg_data;
                REG_TARGET:      target_reg <= cfg_data[15:0];
                REG_TOL:         tol_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            beam_reg      <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            in_seg_reg    <= 1'b0;
            found_reg     <= 1'b0;
            len_reg       <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            beam_reg      <= beam_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
            in_seg_reg    <= in_seg_next;
            found_reg     <= found_next;
            len_reg       <= len_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        last_reg     <= last_next;
        q_reg        <= q_next;
        z_reg        <= z_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        step_reg     <= step_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        d2_reg       <= d2_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        sq_phase_reg <= sq_phase_next;
        gap_reg      <= gap_next;
        o_found_reg  <= o_found_next;
        o_cnt_reg    <= o_cnt_next;
        o_sx_reg     <= o_sx_next;
        o_sy_reg     <= o_sy_next;
        o_len_reg    <= o_len_next;
    end

    function automatic logic signed [16:0] clamp17(input logic signed [22:0] v);
        logic signed [16:0] c;
        if (v > 23'sd65535)
            c = 17'sd65535;
        else if (v < -23'sd65536)
            c = -17'sd65536;
        else
            c = v[16:0];
        return c;
    endfunction

    function automatic logic signed [28:0] sat_add(input logic signed [28:0] a,
                                                   input logic signed [16:0] b);
        logic signed [29:0] s;
        s = 30'(a) + 30'(b);
        if (s > 30'sd268435455)
            s = 30'sd268435455;
        else if (s < -30'sd268435456)
            s = -30'sd268435456;
        return s[28:0];
    endfunction

    // shared datapath signals
    logic [31:0] ang_full;
    logic [ANGLE_BITS-1:0] ang;
    logic [31:0] phase, d_ph;
    logic [1:0] q_w;
    logic [45:0] scale_prod;
    logic signed [35:0] shx, shy;
    logic signed [22:0] rx, ry;
    logic [35:0] sq_x, sq_y;
    logic [34:0] trial;
    logic [24:0] len_sum;
    logic signed [18:0] hi_b, lo_b;
    logic signed [25:0] twice;

    always_comb
    begin
        state_next     = state_reg;
        beam_next      = beam_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        in_seg_next    = in_seg_reg;
        found_next     = found_reg;
        len_next       = len_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        last_next      = last_reg;
        q_next         = q_reg;
        z_next         = z_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        step_next      = step_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        d2_next        = d2_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        sq_phase_next  = sq_phase_reg;
        gap_next       = gap_reg;
        out_valid_next = out_valid_reg;
        o_found_next   = o_found_reg;
        o_cnt_next     = o_cnt_reg;
        o_sx_next      = o_sx_reg;
        o_sy_next      = o_sy_reg;
        o_len_next     = o_len_reg;

        ang_full   = 32'(astart_reg) + 32'(beam_reg) * 32'(astep_reg);
        ang        = ang_full[ANGLE_BITS-1:0];
        phase      = {ang, {(32-ANGLE_BITS){1'b0}}};
        q_w        = 2'(((phase + 32'h20000000) >> 30));
        d_ph       = phase - {q_w, 30'd0};
        scale_prod = 46'(r_reg) * 46'(KINV_Q30) + 46'd32768;
        shx        = cx_reg >>> step_reg[4:0];
        shy        = cy_reg >>> step_reg[4:0];
        rx         = 23'((cx_reg + 36'sd8192) >>> 14);
        ry         = 23'((cy_reg + 36'sd8192) >>> 14);
        sq_x       = 36'($signed(dx_reg) * $signed(dx_reg));
        sq_y       = 36'($signed(dy_reg) * $signed(dy_reg));
        trial      = root_reg + bit_reg;
        len_sum    = 25'(len_reg) + 25'(gap_reg);
        twice      = {1'b0, len_reg, 1'b0};
        hi_b       = 19'(target_reg) * 19'sd2 + 19'(tol_reg);
        lo_b       = 19'(target_reg) * 19'sd2 - 19'(tol_reg) * 19'sd3;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    r_next     = range_mm;
                    last_next  = last_in_scan;
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE:
            begin
                q_next = q_w;
                z_next = {d_ph[31], d_ph};
                if (!found_reg && r_reg < rmax_reg && r_reg > rmin_reg)
                    state_next = ST_SCALE;
                else
                    state_next = ST_FINISH;
            end
            ST_SCALE:
            begin
                cx_next   = 36'(scale_prod[45:16]);
                cy_next   = '0;
                step_next = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (step_reg == 6'(CORDIC_STEPS))
                    state_next = ST_ROUND;
                else
                begin
                    if (!z_reg[32])
                    begin
                        cx_next = cx_reg - shy;
                        cy_next = cy_reg + shx;
                        z_next  = z_reg - 33'(atan_turn(step_reg[4:0]));
                    end
                    else
                    begin
                        cx_next = cx_reg + shy;
                        cy_next = cy_reg - shx;
                        z_next  = z_reg + 33'(atan_turn(step_reg[4:0]));
                    end
                    step_next = step_reg + 6'd1;
                end
            end
            ST_ROUND:
            begin
                unique case (q_reg)
                    2'd0: begin x_next = clamp17(rx);  y_next = clamp17(ry);  end
                    2'd1: begin x_next = clamp17(-ry); y_next = clamp17(rx);  end
                    2'd2: begin x_next = clamp17(-rx); y_next = clamp17(-ry); end
                    default: begin x_next = clamp17(ry); y_next = clamp17(-rx); end
                endcase
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dx_next = 18'(x_reg) - 18'(prev_x_reg);
                dy_next = 18'(y_reg) - 18'(prev_y_reg);
                if (have_prev_reg)
                    state_next = ST_SQUARE;
                else
                    state_next = ST_UPDATE;
            end
            ST_SQUARE:
            begin
                d2_next       = 35'(sq_x) + 35'(sq_y);
                rem_next      = 35'(sq_x) + 35'(sq_y);
                root_next     = '0;
                bit_next      = 35'h400000000;
                sq_phase_next = 1'b0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                // bit walk-down then digit iterations, then rounding
                if (!sq_phase_reg)
                begin
                    if (bit_reg > d2_reg)
                        bit_next = bit_reg >> 2;
                    else
                        sq_phase_next = 1'b1;
                end
                else if (bit_reg != '0)
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_next  = rem_reg - trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_next = root_reg >> 1;
                    bit_next = bit_reg >> 2;
                end
                else
                begin
                    gap_next   = 24'(root_reg) + 24'(rem_reg > root_reg);
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (have_prev_reg)
                begin
                    if (d2_reg < 35'(join_reg))
                    begin
                        if (!in_seg_reg)
                        begin
                            in_seg_next = 1'b1;
                            len_next = len_reg;
                            sx_next = '0;
                            sy_next = '0;
                            cnt_next = '0;
                            gap_next = gap_reg;
                            len_next = (25'(gap_reg) > 25'(LEN_MAX)) ? LEN_MAX : gap_reg;
                            sx_next = sat_add(29'sd0, x_reg);
                            sy_next = sat_add(29'sd0, y_reg);
                            cnt_next = 13'd1;
                        end
                        else
                        begin
                            len_next = len_sum[24] ? LEN_MAX : len_sum[23:0];
                            sx_next  = sat_add(sx_reg, x_reg);
                            sy_next  = sat_add(sy_reg, y_reg);
                            if (cnt_reg != CNT_MAX)
                                cnt_next = cnt_reg + 13'd1;
                        end
                    end
                    else
                    begin
                        if (in_seg_reg)
                        begin
                            if (twice < 26'(hi_b) && twice > 26'(lo_b))
                            begin
                                sx_next = sat_add(sx_reg, x_reg);
                                sy_next = sat_add(sy_reg, y_reg);
                                if (cnt_reg != CNT_MAX)
                                    cnt_next = cnt_reg + 13'd1;
                                found_next = 1'b1;
                            end
                            else
                            begin
                                len_next = '0;
                                sx_next  = '0;
                                sy_next  = '0;
                                cnt_next = '0;
                            end
                        end
                        in_seg_next = 1'b0;
                    end
                end
                prev_x_next    = x_reg;
                prev_y_next    = y_reg;
                have_prev_next = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                beam_next = beam_reg + BEAM_W'(1);
                if (last_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    o_found_next   = found_reg;
                    o_cnt_next     = found_reg ? cnt_reg : '0;
                    o_sx_next      = found_reg ? sx_reg : '0;
                    o_sy_next      = found_reg ? sy_reg : '0;
                    o_len_next     = found_reg ? len_reg : '0;
                    beam_next      = '0;
                    prev_x_next    = '0;
                    prev_y_next    = '0;
                    have_prev_next = 1'b0;
                    in_seg_next    = 1'b0;
                    found_next     = 1'b0;
                    len_next       = '0;
                    sx_next        = '0;
                    sy_next        = '0;
                    cnt_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign found         = o_found_reg;
    assign seg_points    = o_cnt_reg;
    assign seg_sum_x     = o_sx_reg;
    assign seg_sum_y     = o_sy_reg;
    assign seg_length_mm = o_len_reg;

endmodule

// File: sv/lasd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasd_checker
// Port-level checks on the arc segment detector.
// ----------------------------------------------------------------------------
module lasd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [12:0] seg_points,
    input logic [23:0] seg_length_mm
);
    // a result without a match carries zeros
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> seg_points == 13'd0 && seg_length_mm == 24'd0)
        else $error("empty result not zero");

    // a match always holds at least one point
    a_pts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> seg_points != 13'd0)
        else $error("match without points");

    // an accepted item blocks the next cycle's intake
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found))
        else $error("stalled result changed");

endmodule

bind lidar_arc_segment_detector lasd_checker u_lasd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .found(found),
    .seg_points(seg_points), .seg_length_mm(seg_length_mm)
);

// File: verif/lidar_arc_segment_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_arc_segment_detector_tb
// Drives lidar scans into the segment detector and checks each scan report.
// A scan predictor in the bench computes the expected report for every
// accepted last-of-scan item. It covers several register settings, random
// sender gaps and receiver stalls, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module lidar_arc_segment_detector_tb;
    import lasd_pkg::*;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  SETTLE       = 120;

    typedef struct packed {
        logic [15:0] range;
        logic        last;
    } beam_t;

    typedef struct packed {
        logic               found;
        logic [12:0]        points;
        logic signed [28:0] sum_x;
        logic signed [28:0] sum_y;
        logic [23:0]        length;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] range_mm = '0;
    logic        last_in_scan = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic        found;
    logic [12:0] seg_points;
    logic signed [28:0] seg_sum_x;
    logic signed [28:0] seg_sum_y;
    logic [23:0] seg_length_mm;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    lidar_arc_segment_detector dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    beam_t   beam_q[$];
    report_t report_q[$];
    int      errors = 0;
    int      cycles = 0;
    bit      quiet = 1'b0;
    logic    rx_hold = 1'b0;

    // predictor copy of registers and scan state
    logic [31:0] p_reg[7];
    logic [11:0] p_beam;
    longint      p_prev_x, p_prev_y, p_sum_x, p_sum_y;
    bit          p_have_prev, p_in_seg, p_found;
    longint unsigned p_len, p_count;

    localparam logic [31:0] ATAN_T[24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    function automatic longint clip17(longint v);
        if (v > 65535) return 65535;
        if (v < -65536) return -65536;
        return v;
    endfunction

    function automatic longint clip29(longint v);
        if (v > 268435455) return 268435455;
        if (v < -268435456) return -268435456;
        return v;
    endfunction

    function automatic void rotate_beam(input logic [15:0] r, input logic [31:0] phase,
                                        output longint xo, output longint yo);
        logic [1:0]  q;
        logic [31:0] d;
        longint      z, x, y, nx, ny, rx, ry;
        q = 2'((phase + 32'h20000000) >> 30);
        d = phase - {q, 30'd0};
        z = longint'($signed(d));
        x = (longint'(r) * 652032874 + 32768) >>> 16;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - longint'(ATAN_T[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + longint'(ATAN_T[i]);
            end
            x = nx;
            y = ny;
        end
        rx = (x + 8192) >>> 14;
        ry = (y + 8192) >>> 14;
        case (q)
            2'd0: begin xo = clip17(rx);  yo = clip17(ry);  end
            2'd1: begin xo = clip17(-ry); yo = clip17(rx);  end
            2'd2: begin xo = clip17(-rx); yo = clip17(-ry); end
            default: begin xo = clip17(ry); yo = clip17(-rx); end
        endcase
    endfunction

    function automatic longint unsigned gap_length(longint unsigned v);
        longint unsigned rem, root, b;
        rem  = v;
        root = 0;
        b    = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        if (rem > root) root++;
        return root;
    endfunction

    function automatic void add_to_segment(longint x, longint y);
        p_sum_x = clip29(p_sum_x + x);
        p_sum_y = clip29(p_sum_y + y);
        if (p_count < 8191) p_count++;
    endfunction

    function automatic void clear_segment();
        p_len = 0; p_sum_x = 0; p_sum_y = 0; p_count = 0;
    endfunction

    function automatic void clear_scan();
        p_beam = '0; p_prev_x = 0; p_prev_y = 0;
        p_have_prev = 0; p_in_seg = 0; p_found = 0;
        clear_segment();
    endfunction

    // one accepted beam; queues a report on the last beam of a scan
    function automatic void predict_beam(logic [15:0] r, logic last);
        logic [15:0] ang;
        longint x, y, dx, dy, twice, hi, lo;
        longint unsigned d2;
        report_t rep;
        if (!p_found && r < p_reg[REG_RANGE_MAX][15:0] && r > p_reg[REG_RANGE_MIN][15:0])
        begin
            ang = p_reg[REG_ANGLE_START][15:0] + 16'(p_beam * p_reg[REG_ANGLE_STEP][15:0]);
            rotate_beam(r, {ang, 16'd0}, x, y);
            if (p_have_prev)
            begin
                dx = x - p_prev_x;
                dy = y - p_prev_y;
                d2 = longint'(dx * dx) + longint'(dy * dy);
                if (d2 < longint'(p_reg[REG_JOIN_SQ]))
                begin
                    if (!p_in_seg)
                    begin
                        p_in_seg = 1;
                        clear_segment();
                    end
                    p_len = p_len + gap_length(d2);
                    if (p_len > 24'hFFFFFF) p_len = 24'hFFFFFF;
                    add_to_segment(x, y);
                end
                else
                begin
                    if (p_in_seg)
                    begin
                        twice = 2 * longint'(p_len);
                        hi = 2 * longint'(p_reg[REG_TARGET][15:0]) + longint'(p_reg[REG_TOL][15:0]);
                        lo = 2 * longint'(p_reg[REG_TARGET][15:0])
                             - 3 * longint'(p_reg[REG_TOL][15:0]);
                        if (twice < hi && twice > lo)
                        begin
                            add_to_segment(x, y);
                            p_found = 1;
                        end
                        else
                            clear_segment();
                    end
                    p_in_seg = 0;
                end
            end
            p_prev_x = x;
            p_prev_y = y;
            p_have_prev = 1;
        end
        p_beam = p_beam + 12'd1;
        if (last)
        begin
            if (p_found)
            begin
                rep.found  = 1'b1;
                rep.points = 13'(p_count);
                rep.sum_x  = 29'(p_sum_x);
                rep.sum_y  = 29'(p_sum_y);
                rep.length = 24'(p_len);
            end
            else
                rep = '0;
            report_q = {report_q, rep};
            clear_scan();
        end
    endfunction

    function automatic int draw_wait();
        if (quiet) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    endfunction

    // sender
    int tx_gap = 0;
    always @(posedge clk)
    begin
        beam_t b;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_beam(range_mm, last_in_scan);
                tx_gap = draw_wait();
            end
            if (!(in_valid && in_stall))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (beam_q.size() != 0)
                begin
                    b = beam_q.pop_front();
                    range_mm     <= b.range;
                    last_in_scan <= b.last;
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    int rx_wait = 0;
    always @(posedge clk)
    begin
        report_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (report_q.size() == 0)
                begin
                    $error("report with no scan pending");
                    errors++;
                end
                else
                begin
                    e = report_q.pop_front();
                    if (found !== e.found)
                    begin
                        $error("found: expected %0d actual %0d", e.found, found);
                        errors++;
                    end
                    if (seg_points !== e.points)
                    begin
                        $error("seg_points: expected %0d actual %0d", e.points, seg_points);
                        errors++;
                    end
                    if (seg_sum_x !== e.sum_x)
                    begin
                        $error("seg_sum_x: expected %0d actual %0d", e.sum_x, seg_sum_x);
                        errors++;
                    end
                    if (seg_sum_y !== e.sum_y)
                    begin
                        $error("seg_sum_y: expected %0d actual %0d", e.sum_y, seg_sum_y);
                        errors++;
                    end
                    if (seg_length_mm !== e.length)
                    begin
                        $error("seg_length_mm: expected %0d actual %0d", e.length,
                               seg_length_mm);
                        errors++;
                    end
                end
                rx_wait = draw_wait();
            end
            out_stall <= rx_hold || (rx_wait > 0);
            if (rx_wait > 0) rx_wait--;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic put_beam(int r, bit last);
        beam_t b;
        b.range = 16'(r);
        b.last  = last;
        beam_q = {beam_q, b};
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        p_reg[idx] = (idx == REG_JOIN_SQ) ? val : {16'd0, val[15:0]};
    endtask

    task automatic set_regs(int rmax, int rmin, int a0, int astep, logic [31:0] join_sq,
                            int target, int tol);
        write_reg(REG_RANGE_MAX, rmax);
        write_reg(REG_RANGE_MIN, rmin);
        write_reg(REG_ANGLE_START, a0);
        write_reg(REG_ANGLE_STEP, astep);
        write_reg(REG_JOIN_SQ, join_sq);
        write_reg(REG_TARGET, target);
        write_reg(REG_TOL, tol);
    endtask

    // wait until the block is idle and every report is in
    task automatic drain();
        while (beam_q.size() != 0 || in_valid || report_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // runs of near-constant range closed by a far point, random content
    task automatic arc_scan();
        int n, base, k;
        n = $urandom_range(25, 70);
        while (n > 1)
        begin
            base = $urandom_range(300, 2400);
            k = $urandom_range(3, 45);
            for (int i = 0; i < k && n > 1; i++, n--)
            begin
                if ($urandom_range(0, 15) == 0)
                    put_beam($urandom_range(0, 120), 0);
                else
                    put_beam(base + $urandom_range(0, 8) - 4, 0);
            end
            if (n > 1)
            begin
                put_beam(base > 1300 ? base - 900 : base + 900, 0);
                n--;
            end
        end
        put_beam($urandom_range(0, 65535), 1);
    endtask

    task automatic noise_scan();
        int n;
        n = $urandom_range(0, 20);
        repeat (n) put_beam($urandom_range(0, 65535), $urandom_range(0, 7) == 0);
        put_beam($urandom_range(0, 65535), 1);
    endtask

    task automatic random_scans(int items);
        int goal;
        goal = beam_q.size() + items;
        while (beam_q.size() < goal)
        begin
            if ($urandom_range(0, 4) == 0) noise_scan();
            else arc_scan();
        end
    endtask

    initial
    begin
        p_reg[REG_RANGE_MAX]   = 2600;
        p_reg[REG_RANGE_MIN]   = 120;
        p_reg[REG_ANGLE_START] = 32768;
        p_reg[REG_ANGLE_STEP]  = 182;
        p_reg[REG_JOIN_SQ]     = 200000;
        p_reg[REG_TARGET]      = 471;
        p_reg[REG_TOL]         = 100;
        clear_scan();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed: range limits, one-beam scan, a short segment closed outside the band, open at scan end
        put_beam(0, 0); put_beam(65535, 0); put_beam(120, 0); put_beam(121, 0);
        put_beam(2599, 0); put_beam(2600, 1);
        put_beam(1000, 1);
        for (int i = 0; i < 6; i++) put_beam(1000, 0);
        put_beam(2000, 1);
        for (int i = 0; i < 6; i++) put_beam(500, 0);
        put_beam(500, 1);
        drain();

        random_scans(350);
        drain();

        // receiver holds off while the sender keeps offering
        random_scans(150);
        rx_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold <= 1'b0;
        drain();

        set_regs(65535, 0, 0, 65535, 32'hFFFFFFFF, 65535, 65535);
        random_scans(120);
        drain();

        set_regs(0, 0, 65535, 0, 32'h0, 0, 0);
        random_scans(40);
        drain();

        quiet = 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_regs($urandom_range(1500, 65535), $urandom_range(0, 300),
                     $urandom_range(0, 65535), $urandom_range(50, 400),
                     $urandom_range(10000, 1000000), $urandom_range(200, 900),
                     $urandom_range(20, 300));
            random_scans(150);
            drain();
            quiet = 1'b0;
        end

        // one long flat segment at the coordinate limit closed by a far point
        set_regs(65535, 0, 32768, 0, 32'h80000000, 0, 1);
        repeat (150) put_beam(65000, 0);
        put_beam(100, 0);
        put_beam(5000, 1);
        drain();

        set_regs(2600, 120, 32768, 182, 200000, 471, 100);
        random_scans(80);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: lidar_arc_segment_detector.f
sv/lasd_pkg.sv
sv/lidar_arc_segment_detector.sv
sv/lasd_checker.sv
verif/lidar_arc_segment_detector_tb.sv
